[design/pec_pkg.sv]
// Shared types, constants and the fixed-point product for the easing curve block.
package pec_pkg;

   // Field widths of the channels and registers.
   localparam int PROG_W      = 17;
   localparam int OUT_W       = 19;
   localparam int POINT_W     = 18;
   localparam int CURVE_W     = 5;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 18;

   // Fixed-point format and datapath sizing.
   // Every intermediate value of every curve stays below 2^25 in magnitude for any
   // 17-bit progress, so a 26-bit signed word holds it without loss.
   localparam int FRAC_BITS  = 16;
   localparam int VAL_W      = 26;
   localparam int SUM_W      = VAL_W + 4;
   localparam int LANES      = 4;
   localparam int MUL_STAGES = 4;

   typedef logic signed [VAL_W-1:0]   value_type;
   typedef logic signed [POINT_W-1:0] point_type;

   // Common fixed-point values.
   localparam int ONE_FX   = 1 << FRAC_BITS;
   localparam int HALF_FX  = ONE_FX / 2;
   localparam int TWO_FX   = 2 * ONE_FX;
   localparam int THREE_FX = 3 * ONE_FX;

   // Band edges and centers of the bounce and rubber curves, rounded to nearest.
   localparam int BAND_TOP_EDGE     = (2 * 9 * ONE_FX + 10) / 20;
   localparam int BAND_UPPER_EDGE   = (2 * 3 * ONE_FX + 4) / 8;
   localparam int BAND_TOP_CENTER   = (2 * 19 * ONE_FX + 20) / 40;
   localparam int BAND_UPPER_CENTER = (2 * 33 * ONE_FX + 40) / 80;
   localparam int BAND_MID_CENTER   = (2 * 5 * ONE_FX + 8) / 16;

   // Band offsets and gains.
   localparam int BOUNCE_TOP_OFFSET   = (2 * 1 * ONE_FX + 20) / 40;
   localparam int BOUNCE_UPPER_OFFSET = (2 * 9 * ONE_FX + 100) / 200;
   localparam int BOUNCE_MID_OFFSET   = (2 * 3 * ONE_FX + 16) / 32;
   localparam int RUBBER_TOP_OFFSET   = (2 * 1 * ONE_FX + 20) / 40;
   localparam int RUBBER_UPPER_OFFSET = (2 * 81 * ONE_FX + 800) / 1600;
   localparam int RUBBER_MID_OFFSET   = (2 * 7 * ONE_FX + 32) / 64;
   localparam int BOUNCE_TOP_GAIN     = 20;
   localparam int BOUNCE_UPPER_GAIN   = 16;
   localparam int BOUNCE_MID_GAIN     = 12;
   localparam int RUBBER_TOP_GAIN     = 20;
   localparam int RUBBER_UPPER_GAIN   = 18;
   localparam int RUBBER_MID_GAIN     = 14;

   // Gains of the in-out curves on their halves, and of the Bezier middle terms.
   localparam int QUAD_HALF_GAIN  = 2;
   localparam int QUAD_LIN_GAIN   = 4;
   localparam int CUBIC_HALF_GAIN = 4;
   localparam int QUART_HALF_GAIN = 8;
   localparam int QUINT_HALF_GAIN = 16;
   localparam int BEZIER_GAIN     = 3;

   // Output saturation limits.
   localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
   localparam int OUT_MIN = -(1 << (OUT_W - 1));

   // Curve selector codes.
   localparam logic [CURVE_W-1:0] CURVE_LINEAR      = CURVE_W'(0);
   localparam logic [CURVE_W-1:0] CURVE_EASY        = CURVE_W'(1);
   localparam logic [CURVE_W-1:0] CURVE_EASY_SLOW   = CURVE_W'(2);
   localparam logic [CURVE_W-1:0] CURVE_DROP        = CURVE_W'(3);
   localparam logic [CURVE_W-1:0] CURVE_DROP_SLOW   = CURVE_W'(4);
   localparam logic [CURVE_W-1:0] CURVE_BOUNCE      = CURVE_W'(5);
   localparam logic [CURVE_W-1:0] CURVE_RUBBER      = CURVE_W'(6);
   localparam logic [CURVE_W-1:0] CURVE_QUAD_IN     = CURVE_W'(7);
   localparam logic [CURVE_W-1:0] CURVE_QUAD_OUT    = CURVE_W'(8);
   localparam logic [CURVE_W-1:0] CURVE_QUAD_INOUT  = CURVE_W'(9);
   localparam logic [CURVE_W-1:0] CURVE_CUBIC_IN    = CURVE_W'(10);
   localparam logic [CURVE_W-1:0] CURVE_CUBIC_OUT   = CURVE_W'(11);
   localparam logic [CURVE_W-1:0] CURVE_CUBIC_INOUT = CURVE_W'(12);
   localparam logic [CURVE_W-1:0] CURVE_QUART_IN    = CURVE_W'(13);
   localparam logic [CURVE_W-1:0] CURVE_QUART_OUT   = CURVE_W'(14);
   localparam logic [CURVE_W-1:0] CURVE_QUART_INOUT = CURVE_W'(15);
   localparam logic [CURVE_W-1:0] CURVE_QUINT_IN    = CURVE_W'(16);
   localparam logic [CURVE_W-1:0] CURVE_QUINT_OUT   = CURVE_W'(17);
   localparam logic [CURVE_W-1:0] CURVE_QUINT_INOUT = CURVE_W'(18);
   localparam logic [CURVE_W-1:0] CURVE_BEZIER      = CURVE_W'(19);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_CURVE_SELECT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_ZERO   = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_ONE    = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_TWO    = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_THREE  = CSR_INDEX_W'(4);

   // Progress band of the bounce and rubber curves.
   typedef enum logic [1:0] {
      BAND_LOW,
      BAND_MID,
      BAND_UPPER,
      BAND_TOP
   } band_type;

   // Control that travels with each beat down the pipeline.
   typedef struct packed {
      logic               valid;
      logic [CURVE_W-1:0] curve;
      logic               half;
      band_type           band;
      logic [PROG_W-1:0]  progress;
   } ctl_type;

   // Fixed-point product, truncated toward minus infinity.
   function automatic value_type fx_mul(input value_type a, input value_type b);
      logic signed [2*VAL_W-1:0] prod;
      logic signed [2*VAL_W-1:0] shifted;
      prod    = a * b;
      shifted = prod >>> FRAC_BITS;
      return shifted[VAL_W-1:0];
   endfunction

endpackage

[design/pec_prep.sv]
// Input stage: band decode and per-curve operand preparation.
module pec_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [pec_pkg::PROG_W-1:0]    progress,
   input  logic [pec_pkg::CURVE_W-1:0]   curve,
   output pec_pkg::ctl_type              dn_ctl,
   output pec_pkg::value_type            dn_x,
   output pec_pkg::value_type            dn_y
);
   import pec_pkg::*;

   ctl_type   ctl_in;
   ctl_type   ctl_ff;
   value_type x_in;
   value_type x_ff;
   value_type y_in;
   value_type y_ff;
   value_type p_val;
   value_type band_d;
   band_type  band;
   logic      half;

   assign p_val = {{(VAL_W - PROG_W){1'b0}}, progress};
   assign half  = p_val < VAL_W'(HALF_FX);

   // Pick the band and the offset from its center for bounce and rubber (2p when low).
   always_comb begin
      if (p_val > VAL_W'(BAND_TOP_EDGE)) begin
         band   = BAND_TOP;
         band_d = p_val - VAL_W'(BAND_TOP_CENTER);
      end else if (p_val > VAL_W'(BAND_UPPER_EDGE)) begin
         band   = BAND_UPPER;
         band_d = p_val - VAL_W'(BAND_UPPER_CENTER);
      end else if (p_val > VAL_W'(HALF_FX)) begin
         band   = BAND_MID;
         band_d = p_val - VAL_W'(BAND_MID_CENTER);
      end else begin
         band   = BAND_LOW;
         band_d = p_val <<< 1;
      end
   end

   // The base x is what gets raised to a power; y is the second factor some curves need.
   always_comb begin
      case (curve)
         CURVE_BOUNCE, CURVE_RUBBER: begin
            x_in = band_d;
         end
         CURVE_CUBIC_OUT, CURVE_QUART_OUT, CURVE_QUINT_OUT: begin
            x_in = p_val - VAL_W'(ONE_FX);
         end
         CURVE_QUART_INOUT: begin
            x_in = half ? p_val : p_val - VAL_W'(ONE_FX);
         end
         CURVE_CUBIC_INOUT, CURVE_QUINT_INOUT: begin
            x_in = half ? p_val : (p_val <<< 1) - VAL_W'(TWO_FX);
         end
         CURVE_BEZIER: begin
            x_in = VAL_W'(ONE_FX) - p_val;
         end
         default: begin
            x_in = p_val;
         end
      endcase

      case (curve)
         CURVE_EASY, CURVE_EASY_SLOW: begin
            y_in = VAL_W'(THREE_FX) - (p_val <<< 1);
         end
         CURVE_QUAD_OUT: begin
            y_in = VAL_W'(TWO_FX) - p_val;
         end
         CURVE_QUART_OUT: begin
            y_in = VAL_W'(ONE_FX) - p_val;
         end
         CURVE_BEZIER: begin
            y_in = p_val;
         end
         default: begin
            y_in = VAL_W'(ONE_FX);
         end
      endcase
   end

   // Control for the beat.
   always_comb begin
      ctl_in.valid    = in_valid;
      ctl_in.curve    = curve;
      ctl_in.half     = half;
      ctl_in.band     = band;
      ctl_in.progress = progress;
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   assign dn_ctl = ctl_ff;
   assign dn_x   = x_ff;
   assign dn_y   = y_ff;

endmodule

[design/pec_mul_stage.sv]
// One multiplier stage: four product lanes with per-curve operand routing.
module pec_mul_stage #(
   parameter int STAGE = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pec_pkg::ctl_type     up_ctl,
   input  pec_pkg::value_type   up_x,
   input  pec_pkg::value_type   up_y,
   input  pec_pkg::value_type   up_lane [pec_pkg::LANES],
   input  pec_pkg::point_type   point [pec_pkg::LANES],
   output pec_pkg::ctl_type     dn_ctl,
   output pec_pkg::value_type   dn_x,
   output pec_pkg::value_type   dn_y,
   output pec_pkg::value_type   dn_lane [pec_pkg::LANES]
);
   import pec_pkg::*;

   ctl_type   ctl_ff;
   value_type x_ff;
   value_type y_ff;
   value_type a_op [LANES];
   value_type b_op [LANES];
   value_type lane_in [LANES];
   value_type lane_ff [LANES];

   // Operand routing. A lane that has nothing to do multiplies by one, which passes
   // its value through unchanged.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         a_op[i] = up_lane[i];
         b_op[i] = VAL_W'(ONE_FX);
      end
      case (up_ctl.curve)
         CURVE_EASY: begin
            if (STAGE == 1) begin
               b_op[0] = up_x;
            end else if (STAGE == 2) begin
               b_op[0] = up_y;
            end
         end
         CURVE_EASY_SLOW: begin
            // First pass of the easy curve, then the same curve on its result.
            if (STAGE == 1) begin
               b_op[0] = up_x;
            end else if (STAGE == 2) begin
               b_op[0] = up_y;
            end else if (STAGE == 3) begin
               b_op[0] = up_lane[0];
               a_op[1] = up_lane[0];
            end else if (STAGE == 4) begin
               b_op[0] = VAL_W'(THREE_FX) - (up_lane[1] <<< 1);
            end
         end
         CURVE_DROP, CURVE_BOUNCE, CURVE_RUBBER, CURVE_QUAD_IN, CURVE_QUAD_INOUT: begin
            if (STAGE == 1) begin
               b_op[0] = up_x;
            end
         end
         CURVE_QUAD_OUT: begin
            if (STAGE == 1) begin
               b_op[0] = up_y;
            end
         end
         CURVE_CUBIC_IN, CURVE_CUBIC_OUT, CURVE_CUBIC_INOUT: begin
            if (STAGE <= 2) begin
               b_op[0] = up_x;
            end
         end
         CURVE_QUART_IN, CURVE_QUART_INOUT: begin
            if (STAGE <= 3) begin
               b_op[0] = up_x;
            end
         end
         CURVE_QUART_OUT: begin
            if (STAGE <= 2) begin
               b_op[0] = up_x;
            end else if (STAGE == 3) begin
               b_op[0] = up_y;
            end
         end
         CURVE_DROP_SLOW, CURVE_QUINT_IN, CURVE_QUINT_OUT, CURVE_QUINT_INOUT: begin
            b_op[0] = up_x;
         end
         CURVE_BEZIER: begin
            // Lane 0 and 1 start as (1-p) and p; then the four basis products, then
            // each basis term times its control value.
            if (STAGE == 1) begin
               b_op[0] = up_x;
               b_op[1] = up_y;
            end else if (STAGE == 2) begin
               b_op[0] = up_x;
               a_op[1] = up_lane[0];
               b_op[1] = up_y;
               a_op[2] = up_lane[1];
               b_op[2] = up_x;
               a_op[3] = up_lane[1];
               b_op[3] = up_y;
            end else if (STAGE == 3) begin
               for (int i = 0; i < LANES; i++) begin
                  b_op[i] = VAL_W'(point[i]);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Products of all lanes.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         lane_in[i] = fx_mul(a_op[i], b_op[i]);
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= up_x;
      y_ff <= up_y;
      for (int i = 0; i < LANES; i++) begin
         lane_ff[i] <= lane_in[i];
      end
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= up_ctl;
      end
   end

   assign dn_ctl  = ctl_ff;
   assign dn_x    = x_ff;
   assign dn_y    = y_ff;
   assign dn_lane = lane_ff;

endmodule

[design/pec_finish.sv]
// Output stage: per-curve final sum, saturation and the result register.
module pec_finish (
   input  logic                        clock,
   input  logic                        reset,
   input  pec_pkg::ctl_type            up_ctl,
   input  pec_pkg::value_type          up_lane [pec_pkg::LANES],
   output logic                        rsp_valid,
   output logic signed [pec_pkg::OUT_W-1:0] rsp_eased_value,
   output logic                        rsp_clipped
);
   import pec_pkg::*;

   typedef logic signed [SUM_W-1:0] sum_type;

   sum_type r0;
   sum_type r1;
   sum_type r2;
   sum_type r3;
   sum_type p_sum;
   sum_type one_s;
   sum_type sum;
   logic                    valid_ff;
   logic signed [OUT_W-1:0] value_in;
   logic signed [OUT_W-1:0] value_ff;
   logic                    clip_in;
   logic                    clip_ff;

   assign r0    = SUM_W'(up_lane[0]);
   assign r1    = SUM_W'(up_lane[1]);
   assign r2    = SUM_W'(up_lane[2]);
   assign r3    = SUM_W'(up_lane[3]);
   assign p_sum = {{(SUM_W - PROG_W){1'b0}}, up_ctl.progress};
   assign one_s = SUM_W'(ONE_FX);

   // Combine the lane products into the curve value.
   always_comb begin
      case (up_ctl.curve)
         CURVE_EASY, CURVE_EASY_SLOW, CURVE_DROP, CURVE_DROP_SLOW, CURVE_QUAD_IN,
         CURVE_QUAD_OUT, CURVE_CUBIC_IN, CURVE_QUART_IN, CURVE_QUINT_IN: begin
            sum = r0;
         end
         CURVE_BOUNCE: begin
            case (up_ctl.band)
               BAND_TOP: begin
                  sum = one_s + r0 * SUM_W'(BOUNCE_TOP_GAIN) - SUM_W'(BOUNCE_TOP_OFFSET);
               end
               BAND_UPPER: begin
                  sum = one_s + r0 * SUM_W'(BOUNCE_UPPER_GAIN)
                      - SUM_W'(BOUNCE_UPPER_OFFSET);
               end
               BAND_MID: begin
                  sum = one_s + r0 * SUM_W'(BOUNCE_MID_GAIN) - SUM_W'(BOUNCE_MID_OFFSET);
               end
               default: begin
                  sum = r0;
               end
            endcase
         end
         CURVE_RUBBER: begin
            case (up_ctl.band)
               BAND_TOP: begin
                  sum = one_s - r0 * SUM_W'(RUBBER_TOP_GAIN) + SUM_W'(RUBBER_TOP_OFFSET);
               end
               BAND_UPPER: begin
                  sum = one_s + r0 * SUM_W'(RUBBER_UPPER_GAIN)
                      - SUM_W'(RUBBER_UPPER_OFFSET);
               end
               BAND_MID: begin
                  sum = one_s - r0 * SUM_W'(RUBBER_MID_GAIN) + SUM_W'(RUBBER_MID_OFFSET);
               end
               default: begin
                  sum = r0;
               end
            endcase
         end
         CURVE_QUAD_INOUT: begin
            if (up_ctl.half) begin
               sum = r0 * SUM_W'(QUAD_HALF_GAIN);
            end else begin
               sum = p_sum * SUM_W'(QUAD_LIN_GAIN) - r0 * SUM_W'(QUAD_HALF_GAIN) - one_s;
            end
         end
         CURVE_CUBIC_OUT, CURVE_QUART_OUT, CURVE_QUINT_OUT: begin
            sum = r0 + one_s;
         end
         CURVE_CUBIC_INOUT: begin
            sum = up_ctl.half ? r0 * SUM_W'(CUBIC_HALF_GAIN) : (r0 >>> 1) + one_s;
         end
         CURVE_QUART_INOUT: begin
            sum = up_ctl.half ? r0 * SUM_W'(QUART_HALF_GAIN)
                              : one_s - r0 * SUM_W'(QUART_HALF_GAIN);
         end
         CURVE_QUINT_INOUT: begin
            sum = up_ctl.half ? r0 * SUM_W'(QUINT_HALF_GAIN) : (r0 >>> 1) + one_s;
         end
         CURVE_BEZIER: begin
            sum = r0 + (r1 + r2) * SUM_W'(BEZIER_GAIN) + r3;
         end
         default: begin
            sum = p_sum;
         end
      endcase
   end

   // Saturate to the output range and flag it.
   always_comb begin
      if (sum > SUM_W'(OUT_MAX)) begin
         value_in = OUT_W'(OUT_MAX);
         clip_in  = 1'b1;
      end else if (sum < SUM_W'(OUT_MIN)) begin
         value_in = OUT_W'(OUT_MIN);
         clip_in  = 1'b1;
      end else begin
         value_in = sum[OUT_W-1:0];
         clip_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      clip_ff  <= clip_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_eased_value = value_ff;
   assign rsp_clipped     = clip_ff;

endmodule

[design/polynomial_easing_curve.sv]
// Top level of the polynomial easing curve block: registers and the pipeline.
//
// Maps a progress value (unsigned, 16 fraction bits) to an eased value (signed,
// 16 fraction bits, saturated to 19 bits with a clipped flag) along the curve
// picked by curve_select; curve 19 is a cubic Bezier over four control values.
// Input: a beat is taken at each rising edge with start high; busy is always low,
// so a new progress value can be issued in every cycle.
// Output: each result shows on the rsp_ ports for exactly one cycle, marked by
// rsp_valid, in issue order. Throughput is one beat per cycle. The depth is set
// by the longest chain of products (four, for the fifth powers and the doubled
// smoothstep), one registered multiplier stage each, plus an input and an output stage.
// Configuration: csr_ready is always high; index 0 is curve_select, 1 to 4 are the
// Bezier control values. Write registers only while no beat is in flight.
// Reset: synchronous, clears the pipeline valid bits and loads the registers with
// the linear curve and the control values 0, 0, 1, 1. The receiver cannot stall.
module polynomial_easing_curve (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [pec_pkg::PROG_W-1:0]          req_progress,
   output logic                                rsp_valid,
   output logic signed [pec_pkg::OUT_W-1:0]    rsp_eased_value,
   output logic                                rsp_clipped,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pec_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pec_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pec_pkg::*;

   logic [CURVE_W-1:0] curve_ff;
   point_type          point_ff [LANES];
   ctl_type            ctl_bus [MUL_STAGES+1];
   value_type          x_bus [MUL_STAGES+1];
   value_type          y_bus [MUL_STAGES+1];
   value_type          lane_bus [MUL_STAGES+1][LANES];

   // The pipeline never stalls.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         curve_ff    <= CURVE_LINEAR;
         point_ff[0] <= POINT_W'(0);
         point_ff[1] <= POINT_W'(0);
         point_ff[2] <= POINT_W'(ONE_FX);
         point_ff[3] <= POINT_W'(ONE_FX);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CURVE_SELECT: begin
               curve_ff <= csr_wdata[CURVE_W-1:0];
            end
            CSR_POINT_ZERO: begin
               point_ff[0] <= csr_wdata;
            end
            CSR_POINT_ONE: begin
               point_ff[1] <= csr_wdata;
            end
            CSR_POINT_TWO: begin
               point_ff[2] <= csr_wdata;
            end
            CSR_POINT_THREE: begin
               point_ff[3] <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Input stage.
   pec_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .progress (req_progress),
      .curve    (curve_ff),
      .dn_ctl   (ctl_bus[0]),
      .dn_x     (x_bus[0]),
      .dn_y     (y_bus[0])
   );

   // Lanes 0 and 1 start from the prepared operands.
   assign lane_bus[0][0] = x_bus[0];
   assign lane_bus[0][1] = y_bus[0];
   assign lane_bus[0][2] = '0;
   assign lane_bus[0][3] = '0;

   // Multiplier stages.
   for (genvar k = 0; k < MUL_STAGES; k++) begin : g_mul
      pec_mul_stage #(
         .STAGE (k + 1)
      ) u_mul (
         .clock   (clock),
         .reset   (reset),
         .up_ctl  (ctl_bus[k]),
         .up_x    (x_bus[k]),
         .up_y    (y_bus[k]),
         .up_lane (lane_bus[k]),
         .point   (point_ff),
         .dn_ctl  (ctl_bus[k+1]),
         .dn_x    (x_bus[k+1]),
         .dn_y    (y_bus[k+1]),
         .dn_lane (lane_bus[k+1])
      );
   end

   // Output stage.
   pec_finish u_finish (
      .clock           (clock),
      .reset           (reset),
      .up_ctl          (ctl_bus[MUL_STAGES]),
      .up_lane         (lane_bus[MUL_STAGES]),
      .rsp_valid       (rsp_valid),
      .rsp_eased_value (rsp_eased_value),
      .rsp_clipped     (rsp_clipped)
   );

endmodule
